>>> sv/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

    // Fixed widths of the result fields and of the input and output stream data
    localparam int ADDR_FIELD_W = 16;
    localparam int WAY_FIELD_W  = 2;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 24;

    // One lookup result, as it leaves on the output stream
    typedef struct packed {
        logic [ADDR_FIELD_W-1:0] evicted_address;
        logic                    evicted;
        logic [WAY_FIELD_W-1:0]  way_used;
        logic                    hit;
    } sacl_result_t;

    localparam int RESULT_W = $bits(sacl_result_t);

    typedef enum logic {
        POLICY_LRU = 1'b0,
        POLICY_MRU = 1'b1
    } sacl_policy_t;

endpackage

`default_nettype wire

>>> sv/set_assoc_cache_lookup_replace.sv
// Set-associative cache directory with LRU or MRU replacement. Each transfer on the
// input stream carries one block address; the set is taken from its low bits (SETS
// must be a power of two). Each access returns exactly one result transfer: hit, the
// way now holding the block, and on a miss into a full set the evicted flag and the
// replaced address (zero otherwise). A miss fills the lowest empty way first. The
// whole set (valid bits, addresses, ages, last used way) is one row of a synchronous
// memory with one read and one write port; the row is read at the accepting edge and
// is available in the next cycle, where it is updated and written back at the same
// edge as the result is registered. Back-to-back accesses to the same set take the
// updated row from a forwarding register, so the block sustains one access per
// clock while the result is not stalled. The result passes from the lookup stage
// into the output register; a stalled result holds the lookup stage and drops
// s_axis_tready. After reset the rows are cleared one per clock, during which
// s_axis_tready stays low. The user must write replace_policy through cfg_we/cfg_wdata
// only while no access is in flight; the block itself does not enforce this.
`default_nettype none

module set_assoc_cache_lookup_replace
    import sacl_pkg::*;
#(
    parameter int WAYS         = 4,
    parameter int SETS         = 8,
    parameter int ADDRESS_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,      // replace_policy
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] block_address
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] hit, [2:1] way_used, [3] evicted, [19:4] evicted_address, [23:20] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int WAY_W = $clog2(WAYS);
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W = WAYS * (1 + ADDRESS_BITS + WAY_W) + WAY_W;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [SET_W-1:0] clr_idx_reg;
    sacl_policy_t     policy_reg;

    // lookup stage
    logic                    s1_valid_reg;
    logic [ADDRESS_BITS-1:0] s1_addr_reg;
    logic [SET_W-1:0]        s1_set_reg;
    logic                    fwd_reg;
    logic [ROW_W-1:0]        fwd_row_reg;

    // output register
    logic                    m_valid_reg;
    sacl_result_t            m_data_reg;

    // set memory
    logic [ROW_W-1:0] set_mem [SETS];
    logic [ROW_W-1:0] rdata_reg;
    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;

    logic [ADDRESS_BITS-1:0] in_addr;
    logic [SET_W-1:0]        in_set;
    logic                    accept;
    logic                    s1_done;
    logic                    clear_last;
    logic [ROW_W-1:0]        row_cur;
    logic [ROW_W-1:0]        row_new;

    logic [WAYS-1:0]                   rd_valid, wr_valid;
    logic [WAYS-1:0][ADDRESS_BITS-1:0] rd_addr, wr_addr;
    logic [WAYS-1:0][WAY_W-1:0]        rd_age, wr_age;
    logic [WAY_W-1:0]                  rd_last, wr_last;
    sacl_result_t                      upd_result;

    assign in_addr = ADDRESS_BITS'(s_axis_tdata);
    assign in_set  = (SETS > 1) ? SET_W'(in_addr) : '0;

    // Drain the lookup stage only when the output register is free or being taken
    assign s1_done       = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == ST_RUN) && (!s1_valid_reg || s1_done);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign clear_last    = (clr_idx_reg == SET_W'(SETS - 1));

    // Row written back last cycle is not yet visible in the read data: take the copy
    assign row_cur = fwd_reg ? fwd_row_reg : rdata_reg;
    assign {rd_last, rd_age, rd_addr, rd_valid} = row_cur;

    sacl_set_update #(
        .WAYS         (WAYS),
        .ADDRESS_BITS (ADDRESS_BITS),
        .WAY_W        (WAY_W)
    ) u_update (
        .addr      (s1_addr_reg),
        .policy    (policy_reg),
        .ent_valid (rd_valid),
        .ent_addr  (rd_addr),
        .ent_age   (rd_age),
        .ent_last  (rd_last),
        .new_valid (wr_valid),
        .new_addr  (wr_addr),
        .new_age   (wr_age),
        .new_last  (wr_last),
        .result    (upd_result)
    );

    assign row_new = {wr_last, wr_age, wr_addr, wr_valid};

    // Write port: zero rows while clearing, otherwise the updated row
    assign mem_we    = (state_reg == ST_CLEAR) || s1_done;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_idx_reg : s1_set_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : row_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            set_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= set_mem[in_set];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            policy_reg   <= POLICY_LRU;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cfg_we)
            begin
                policy_reg <= sacl_policy_t'(cfg_wdata);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_done && (in_set == s1_set_reg);
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= in_addr;
            s1_set_reg  <= in_set;
            fwd_row_reg <= row_new;
        end
        if (s1_done)
        begin
            m_data_reg <= upd_result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(m_data_reg);

endmodule

`default_nettype wire

>>> sv/sacl_set_update.sv
`default_nettype none

// Compare, victim choice and recency update for one set row.
module sacl_set_update
    import sacl_pkg::*;
#(
    parameter int WAYS         = 4,
    parameter int ADDRESS_BITS = 16,
    parameter int WAY_W        = $clog2(WAYS)
) (
    input  logic [ADDRESS_BITS-1:0]            addr,
    input  sacl_policy_t                       policy,
    input  logic [WAYS-1:0]                    ent_valid,
    input  logic [WAYS-1:0][ADDRESS_BITS-1:0]  ent_addr,
    input  logic [WAYS-1:0][WAY_W-1:0]         ent_age,
    input  logic [WAY_W-1:0]                   ent_last,
    output logic [WAYS-1:0]                    new_valid,
    output logic [WAYS-1:0][ADDRESS_BITS-1:0]  new_addr,
    output logic [WAYS-1:0][WAY_W-1:0]         new_age,
    output logic [WAY_W-1:0]                   new_last,
    output sacl_result_t                       result
);

    localparam int CNT_W = WAY_W + 1;

    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             has_empty;
    logic [WAY_W-1:0] empty_way;
    logic [WAY_W-1:0] lru_way;
    logic [WAY_W-1:0] way;
    logic [CNT_W-1:0] valid_count;
    logic [CNT_W-1:0] old_age;
    logic             evict;

    // Tag compare and empty-way search, lowest way wins
    always_comb
    begin
        hit       = 1'b0;
        hit_way   = '0;
        has_empty = 1'b0;
        empty_way = '0;
        lru_way   = '0;
        for (int k = 0; k < WAYS; k++)
        begin
            if (!hit && ent_valid[k] && ent_addr[k] == addr)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(k);
            end
            if (!has_empty && !ent_valid[k])
            begin
                has_empty = 1'b1;
                empty_way = WAY_W'(k);
            end
            // ages of a full set are a permutation of 0..WAYS-1: the oldest is unique
            if (ent_age[k] == WAY_W'(WAYS - 1))
            begin
                lru_way = WAY_W'(k);
            end
        end
    end

    assign valid_count = CNT_W'($countones(ent_valid));
    assign evict       = !hit && !has_empty;

    always_comb
    begin
        if (hit)
        begin
            way = hit_way;
        end
        else if (has_empty)
        begin
            way = empty_way;
        end
        else if (policy == POLICY_MRU)
        begin
            way = ent_last;
        end
        else
        begin
            way = lru_way;
        end
    end

    // An empty way counts as older than every valid way
    assign old_age = (!hit && has_empty) ? valid_count : {1'b0, ent_age[way]};

    always_comb
    begin
        new_valid = ent_valid;
        new_addr  = ent_addr;
        new_age   = ent_age;
        for (int k = 0; k < WAYS; k++)
        begin
            if (WAY_W'(k) == way)
            begin
                new_age[k] = '0;
                if (!hit)
                begin
                    new_valid[k] = 1'b1;
                    new_addr[k]  = addr;
                end
            end
            else if (ent_valid[k] && {1'b0, ent_age[k]} < old_age)
            begin
                new_age[k] = ent_age[k] + 1'b1;
            end
        end
    end

    assign new_last               = way;
    assign result.hit             = hit;
    assign result.way_used        = WAY_FIELD_W'(way);
    assign result.evicted         = evict;
    assign result.evicted_address = evict ? ADDR_FIELD_W'(ent_addr[way]) : '0;

endmodule

`default_nettype wire

>>> sv/sacl_checker.sv
`default_nettype none

module sacl_checker
    import sacl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    sacl_result_t res;
    assign res = sacl_result_t'(m_axis_tdata[RESULT_W-1:0]);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An offered access holds until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input changed while stalled");

    // Policy is only written with a known value and no result waiting
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !$isunknown(cfg_wdata) && !m_axis_tvalid)
        else $error("policy written while busy");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.hit && res.evicted))
        else $error("hit reported with eviction");

    // No eviction, no evicted address
    a_evict_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !res.evicted |-> res.evicted_address == '0)
        else $error("evicted address without eviction");

endmodule

bind set_assoc_cache_lookup_replace sacl_checker u_sacl_checker (.*);

`default_nettype wire
